@@ hdl/tstr_pkg.sv @@
// Timestamp truncation package: field widths, time constants, unit codes
// and the calendar tables and helpers used by the truncation pipeline.
// No dependencies.
package tstr_pkg;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int TIME_W = 47;
  localparam int UNIT_W = 4;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1400;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [MON_W-1:0]  MON_MAX  = 4'd12;

  localparam logic [TIME_W-1:0] NS_MAX      = 47'd86399999999999;
  localparam logic [TIME_W-1:0] NS_PER_HOUR = 47'd3600000000000;
  localparam logic [TIME_W-1:0] NS_PER_TMIN = 47'd600000000000;
  localparam logic [TIME_W-1:0] NS_PER_MIN  = 47'd60000000000;

  typedef enum logic [UNIT_W-1:0] {
    UNIT_YEAR    = 4'd0,
    UNIT_QUARTER = 4'd1,
    UNIT_MONTH   = 4'd2,
    UNIT_WW      = 4'd3,
    UNIT_WM      = 4'd4,
    UNIT_DAY     = 4'd5,
    UNIT_MONDAY  = 4'd6,
    UNIT_HOUR    = 4'd7,
    UNIT_MINUTE  = 4'd8
  } trunc_unit_e;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the 1st of the month, counted from January 1st, common year
  function automatic logic [8:0] jan_cum(input logic [MON_W-1:0] m);
    logic [8:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // days before the 1st of the month, counted from March 1st
  function automatic logic [8:0] mar_cum(input logic [MON_W-1:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd306;
      4'd2:    c = 9'd337;
      4'd4:    c = 9'd31;
      4'd5:    c = 9'd61;
      4'd6:    c = 9'd92;
      4'd7:    c = 9'd122;
      4'd8:    c = 9'd153;
      4'd9:    c = 9'd184;
      4'd10:   c = 9'd214;
      4'd11:   c = 9'd245;
      4'd12:   c = 9'd275;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic logic [MON_W-1:0] quarter_first(input logic [MON_W-1:0] m);
    logic [MON_W-1:0] q;
    case (m)
      4'd4, 4'd5, 4'd6:    q = 4'd4;
      4'd7, 4'd8, 4'd9:    q = 4'd7;
      4'd10, 4'd11, 4'd12: q = 4'd10;
      default:             q = 4'd1;
    endcase
    return q;
  endfunction

  // y mod 400 for y <= 9999: y/400 = (y>>4)/25, reciprocal 41/1024
  function automatic logic [8:0] mod400(input logic [YEAR_W-1:0] y);
    logic [14:0]       p;
    logic [4:0]        era;
    logic [YEAR_W-1:0] e400;
    logic [YEAR_W-1:0] r;
    p    = 15'(y[YEAR_W-1:4]) * 15'd41;
    era  = p[14:10];
    e400 = (14'(era) << 8) + (14'(era) << 7) + (14'(era) << 4);
    r    = y - e400;
    return r[8:0];
  endfunction

  // x mod 7 for x < 1024: quotient by reciprocal 4682/32768
  function automatic logic [2:0] mod7(input logic [9:0] x);
    logic [22:0] p;
    logic [7:0]  q;
    logic [9:0]  r;
    p = 23'(x) * 23'd4682;
    q = p[22:15];
    r = x - 10'((11'(q) << 3) - 11'(q));
    return r[2:0];
  endfunction

endpackage

@@ hdl/tstr_in_if.sv @@
// Request channel of the timestamp truncation unit: valid/ready and the
// input timestamp fields. Depends on tstr_pkg.
interface tstr_in_if import tstr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [YEAR_W-1:0] in_year;
  logic [MON_W-1:0]  in_month;
  logic [DAY_W-1:0]  in_day;
  logic [TIME_W-1:0] in_time_ns;

  modport source (output valid, in_year, in_month, in_day, in_time_ns, input ready);
  modport sink   (input valid, in_year, in_month, in_day, in_time_ns, output ready);
endinterface

@@ hdl/tstr_out_if.sv @@
// Result channel of the timestamp truncation unit: valid/ready and the
// truncated timestamp fields. Depends on tstr_pkg.
interface tstr_out_if import tstr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [YEAR_W-1:0] out_year;
  logic [MON_W-1:0]  out_month;
  logic [DAY_W-1:0]  out_day;
  logic [TIME_W-1:0] out_time_ns;
  logic              out_null;

  modport source (output valid, out_year, out_month, out_day, out_time_ns, out_null,
                  input ready);
  modport sink   (input valid, out_year, out_month, out_day, out_time_ns, out_null,
                  output ready);
endinterface

@@ hdl/timestamp_truncate_unit.sv @@
// Timestamp truncation unit: four-register pipeline (input, two inner stages,
// result). Depends on tstr_pkg, tstr_in_if and tstr_out_if.
// Throughput: one request per cycle while the output accepts results; each
// stage holds one request and stalls only when the stage after it is full
// and not draining. Reset clears all stage valid flags and sets the unit
// register to day.
module timestamp_truncate_unit import tstr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [UNIT_W-1:0] cfg_wdata_i,
  tstr_in_if.sink           in_req_i,
  tstr_out_if.source        out_rsp_o
);

  logic [UNIT_W-1:0] unit_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: raw request
  logic [YEAR_W-1:0] y1_q;
  logic [MON_W-1:0]  m1_q;
  logic [DAY_W-1:0]  d1_q;
  logic [TIME_W-1:0] t1_q;

  // stage 2: clamped year/month, year mod 400, hour floor
  logic [YEAR_W-1:0] y2_q, y2_d;
  logic [MON_W-1:0]  m2_q, m2_d;
  logic [DAY_W-1:0]  d2_q;
  logic [8:0]        yoe2_q, yoe2_d;
  logic [TIME_W-1:0] hfl2_q, hfl2_d, tc;
  logic [41:0]       rem2_q, rem2_d;

  // stage 3: clamped day, previous month length, weekday offset sum
  logic [YEAR_W-1:0] y3_q;
  logic [MON_W-1:0]  m3_q;
  logic [DAY_W-1:0]  d3_q, d3_d;
  logic [DAY_W-1:0]  mlenp3_q, mlenp3_d;
  logic [9:0]        nsum3_q, nsum3_d;
  logic [TIME_W-1:0] hfl3_q, acc3_q, acc3_d;
  logic [39:0]       rem3_q, rem3_d;

  // stage 4: result
  logic [YEAR_W-1:0] oy_q, oy_d;
  logic [MON_W-1:0]  om_q, om_d;
  logic [DAY_W-1:0]  od_q, od_d;
  logic [TIME_W-1:0] ot_q, ot_d;
  logic              onull_q, onull_d;

  assign rdy4 = !v4_q || out_rsp_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_req_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UNIT_DAY;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unit_q <= cfg_wdata_i;
      end
      if (rdy1) begin
        v1_q <= in_req_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // stage 1 -> 2
  always_comb begin
    if (y1_q < YEAR_MIN) begin
      y2_d = YEAR_MIN;
    end else if (y1_q > YEAR_MAX) begin
      y2_d = YEAR_MAX;
    end else begin
      y2_d = y1_q;
    end
    if (m1_q == '0) begin
      m2_d = 4'd1;
    end else if (m1_q > MON_MAX) begin
      m2_d = MON_MAX;
    end else begin
      m2_d = m1_q;
    end
    yoe2_d = mod400(y2_d);
    tc     = (t1_q > NS_MAX) ? NS_MAX : t1_q;
    hfl2_d = '0;
    for (int k = 1; k < 24; k++) begin
      if (tc >= 47'(k) * NS_PER_HOUR) begin
        hfl2_d = 47'(k) * NS_PER_HOUR;
      end
    end
    rem2_d = 42'(tc - hfl2_d);
  end

  // stage 2 -> 3
  logic             leap;
  logic [DAY_W-1:0] mlen, d0;
  logic [8:0]       yoe_yy;
  logic [1:0]       c100;
  logic [9:0]       wsum;
  logic [41:0]      tfl;

  always_comb begin
    leap = (yoe2_q[1:0] == 2'b00) && (yoe2_q != 9'd100) && (yoe2_q != 9'd200)
           && (yoe2_q != 9'd300);
    mlen = month_len(m2_q, leap);
    d0   = (d2_q == '0) ? 5'd1 : d2_q;
    d3_d = (d0 > mlen) ? mlen : d0;
    mlenp3_d = (m2_q == 4'd1) ? 5'd31 : month_len(m2_q - 4'd1, leap);

    // March-based year for weekday: January and February count with year-1
    if (m2_q <= 4'd2) begin
      yoe_yy = (yoe2_q == '0) ? 9'd399 : yoe2_q - 9'd1;
    end else begin
      yoe_yy = yoe2_q;
    end
    if (yoe_yy >= 9'd300) begin
      c100 = 2'd3;
    end else if (yoe_yy >= 9'd200) begin
      c100 = 2'd2;
    end else if (yoe_yy >= 9'd100) begin
      c100 = 2'd1;
    end else begin
      c100 = 2'd0;
    end
    // days back to Monday, before mod 7
    wsum = 10'(yoe_yy) + 10'(yoe_yy >> 2) - 10'(c100) + 10'(mar_cum(m2_q))
           + 10'(d3_d) + 10'd8;

    case (unit_q)
      UNIT_WW:     nsum3_d = 10'(jan_cum(m2_q)) + 10'(leap && (m2_q > 4'd2))
                             + 10'(d3_d) - 10'd1;
      UNIT_WM:     nsum3_d = 10'(d3_d) - 10'd1;
      UNIT_MONDAY: nsum3_d = wsum;
      default:     nsum3_d = '0;
    endcase

    tfl = '0;
    for (int k = 1; k < 6; k++) begin
      if (rem2_q >= 42'(47'(k) * NS_PER_TMIN)) begin
        tfl = 42'(47'(k) * NS_PER_TMIN);
      end
    end
    acc3_d = hfl2_q + 47'(tfl);
    rem3_d = 40'(rem2_q - tfl);
  end

  // stage 3 -> 4
  logic [2:0]        n;
  logic [YEAR_W-1:0] by;
  logic [MON_W-1:0]  bm;
  logic [DAY_W-1:0]  bd;
  logic [39:0]       mfl;

  always_comb begin
    n = mod7(nsum3_q);
    if (d3_q > 5'(n)) begin
      by = y3_q;
      bm = m3_q;
      bd = d3_q - 5'(n);
    end else begin
      by = (m3_q == 4'd1) ? y3_q - 14'd1 : y3_q;
      bm = (m3_q == 4'd1) ? MON_MAX : m3_q - 4'd1;
      bd = 5'(6'(mlenp3_q) + 6'(d3_q) - 6'(n));
    end

    mfl = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem3_q >= 40'(47'(k) * NS_PER_MIN)) begin
        mfl = 40'(47'(k) * NS_PER_MIN);
      end
    end

    oy_d    = y3_q;
    om_d    = m3_q;
    od_d    = d3_q;
    ot_d    = '0;
    onull_d = 1'b0;
    unique case (unit_q)
      UNIT_YEAR: begin
        om_d = 4'd1;
        od_d = 5'd1;
      end
      UNIT_QUARTER: begin
        om_d = quarter_first(m3_q);
        od_d = 5'd1;
      end
      UNIT_MONTH: od_d = 5'd1;
      UNIT_WW, UNIT_WM, UNIT_MONDAY: begin
        oy_d = by;
        om_d = bm;
        od_d = bd;
      end
      UNIT_DAY: ;
      UNIT_HOUR: ot_d = hfl3_q;
      UNIT_MINUTE: ot_d = acc3_q + 47'(mfl);
      default: begin
        oy_d    = '0;
        om_d    = '0;
        od_d    = '0;
        onull_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_req_i.valid) begin
      y1_q <= in_req_i.in_year;
      m1_q <= in_req_i.in_month;
      d1_q <= in_req_i.in_day;
      t1_q <= in_req_i.in_time_ns;
    end
    if (rdy2 && v1_q) begin
      y2_q   <= y2_d;
      m2_q   <= m2_d;
      d2_q   <= d1_q;
      yoe2_q <= yoe2_d;
      hfl2_q <= hfl2_d;
      rem2_q <= rem2_d;
    end
    if (rdy3 && v2_q) begin
      y3_q     <= y2_q;
      m3_q     <= m2_q;
      d3_q     <= d3_d;
      mlenp3_q <= mlenp3_d;
      nsum3_q  <= nsum3_d;
      hfl3_q   <= hfl2_q;
      acc3_q   <= acc3_d;
      rem3_q   <= rem3_d;
    end
    if (rdy4 && v3_q) begin
      oy_q    <= oy_d;
      om_q    <= om_d;
      od_q    <= od_d;
      ot_q    <= ot_d;
      onull_q <= onull_d;
    end
  end

  assign out_rsp_o.valid       = v4_q;
  assign out_rsp_o.out_year    = oy_q;
  assign out_rsp_o.out_month   = om_q;
  assign out_rsp_o.out_day     = od_q;
  assign out_rsp_o.out_time_ns = ot_q;
  assign out_rsp_o.out_null    = onull_q;

endmodule
